// ===== rtl/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// Trial division primality test: shared types
// Holds the controller state encoding and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_CHECK,
    ST_DIVIDE,
    ST_TEST,
    ST_DONE
  } ptd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // Capture a new candidate.
    logic trial_init;  // Set the divisor to three and its square to nine.
    logic div_start;   // Clear the remainder and load the dividend bits.
    logic div_step;    // Run one step of the restoring remainder.
    logic trial_next;  // Advance to the next odd divisor.
  } ptd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic neg;       // Sign bit of the candidate is set.
    logic lt2;       // Candidate is below two.
    logic lt4;       // Candidate is below four.
    logic even;      // Candidate is even.
    logic sq_gt_n;   // Square of the divisor exceeds the candidate.
    logic div_last;  // The current remainder step is the last one.
    logic rem_zero;  // The remainder is zero.
  } ptd_status_t;

endpackage

// ===== rtl/ptd_datapath.sv =====
// ----------------------------------------------------------------------------
// Trial division primality test: datapath
// Holds the candidate, the odd trial divisor and its square, and a bit-serial
// restoring remainder unit that produces candidate mod divisor.
// ----------------------------------------------------------------------------
module ptd_datapath
  import ptd_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DATA_WIDTH-1:0] candidate_i,
  input  ptd_cmd_t              cmd_i,
  output ptd_status_t           status_o
);

  localparam int CntW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] n_q, n_d;
  logic [DATA_WIDTH-1:0] d_q, d_d;
  logic [DATA_WIDTH:0]   sq_q, sq_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] shreg_q, shreg_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   rem_sub;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  assign rem_sh  = {rem_q, shreg_q[DATA_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, d_q};

  // Next values of the datapath registers.
  always_comb begin
    n_d     = n_q;
    d_d     = d_q;
    sq_d    = sq_q;
    rem_d   = rem_q;
    shreg_d = shreg_q;
    cnt_d   = cnt_q;
    if (cmd_i.load) begin
      n_d = candidate_i;
    end
    if (cmd_i.trial_init) begin
      d_d  = DATA_WIDTH'(3);
      sq_d = (DATA_WIDTH + 1)'(9);
    end
    if (cmd_i.trial_next) begin
      // (d + 2)^2 = d^2 + 4d + 4
      d_d  = d_q + DATA_WIDTH'(2);
      sq_d = sq_q + (DATA_WIDTH + 1)'({d_q, 2'b00}) + (DATA_WIDTH + 1)'(4);
    end
    if (cmd_i.div_start) begin
      rem_d   = '0;
      shreg_d = n_q;
      cnt_d   = '0;
    end
    if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, d_q}) begin
        rem_d = rem_sub[DATA_WIDTH-1:0];
      end else begin
        rem_d = rem_sh[DATA_WIDTH-1:0];
      end
      shreg_d = {shreg_q[DATA_WIDTH-2:0], 1'b0};
      cnt_d   = cnt_q + CntW'(1);
    end
  end

  // Datapath registers; the step counter is the only control-like state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    shreg_q <= shreg_d;
  end

  // Status toward the controller.
  always_comb begin
    status_o.neg      = n_q[DATA_WIDTH-1];
    status_o.lt2      = n_q < DATA_WIDTH'(2);
    status_o.lt4      = n_q < DATA_WIDTH'(4);
    status_o.even     = ~n_q[0];
    status_o.sq_gt_n  = sq_q > {1'b0, n_q};
    status_o.div_last = cnt_q == CntW'(DATA_WIDTH - 1);
    status_o.rem_zero = rem_q == '0;
  end

endmodule

// ===== rtl/ptd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Trial division primality test: controller
// Sequences the early checks, the trial loop over odd divisors and the
// serial remainder steps, and holds the answer for the result beat.
// ----------------------------------------------------------------------------
module ptd_ctrl
  import ptd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  ptd_status_t status_i,
  output ptd_cmd_t    cmd_o,
  output logic        busy,
  output logic        done_o,
  output logic        is_prime_o
);

  ptd_state_e state_q, state_d;
  logic       prime_q, prime_d;

  // Next state and answer.
  always_comb begin
    state_d = state_q;
    prime_d = prime_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (status_i.neg || status_i.lt2) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else if (status_i.lt4) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else if (status_i.even) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.sq_gt_n) begin
          prime_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status_i.rem_zero) begin
          prime_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd_o      = '0;
    busy       = 1'b1;
    done_o     = 1'b0;
    is_prime_o = prime_q;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_CLASSIFY: begin
        cmd_o.trial_init = 1'b1;
      end
      ST_CHECK: begin
        cmd_o.div_start = ~status_i.sq_gt_n;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      ST_TEST: begin
        cmd_o.trial_next = ~status_i.rem_zero;
      end
      ST_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // State and answer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prime_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prime_q <= prime_d;
    end
  end

endmodule

// ===== rtl/prime_trial_division.sv =====
// ----------------------------------------------------------------------------
// Trial division primality test: top level
// A candidate beat is taken when start is high and busy is low; busy stays
// high until the single result beat has been shown on done_o for one cycle,
// and the receiver cannot stall it. Negative values, zero, one, two, three
// and even values are answered by the early checks. Odd values from five
// up run a trial loop over odd divisors d = 3, 5, ... while d*d <=
// candidate, and each trial runs the remainder unit, which takes one
// dividend bit per cycle. A prime ends on one more square check after its
// last trial, with up to roughly sqrt(candidate) / 2 trials. No state is
// kept between items.
// ----------------------------------------------------------------------------
module prime_trial_division
  import ptd_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] candidate_i,
  output logic                         done_o,
  output logic                         is_prime_o
);

  ptd_cmd_t    cmd;
  ptd_status_t status;

  // Sequencing of the checks and the trial loop.
  ptd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy       (busy),
    .done_o     (done_o),
    .is_prime_o (is_prime_o)
  );

  // Candidate, divisor and remainder arithmetic.
  ptd_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .candidate_i (candidate_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Trial division primality test: testbench
// Feeds signed candidates to the block over the start/busy handshake and
// checks every done_o beat against a software primality predictor. A short
// table of corner values runs first, then random candidates in phases with
// sender idle rates of 0, 46, 0 and 16 percent. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module tb;

  localparam int DATA_WIDTH = 32;
  // Cycles one trial costs inside the block.
  localparam int TRIAL_CYCLES = DATA_WIDTH + 2;
  // Random candidates per idle phase.
  localparam int PHASE_BEATS = 150;
  // The largest prime alone runs a long trial loop; random items stay small.
  localparam longint RUN_LIMIT = 64'd200_000_000;

  // One row of the directed table.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         fixed;
    logic                         prime;
  } directed_row_t;

  // One answer waiting for its result beat.
  typedef struct {
    logic [DATA_WIDTH-1:0] value;
    logic                  prime;
  } verdict_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic signed [DATA_WIDTH-1:0] candidate_i;
  logic                         done_o;
  logic                         is_prime_o;

  verdict_t pending_verdicts[$];
  int       fail_count = 0;

  // Corner values; answers are typed in only where they are obvious.
  directed_row_t corner_rows [0:23] = '{
    '{32'sd0,           1'b1, 1'b0},
    '{32'sd1,           1'b1, 1'b0},
    '{32'sd2,           1'b1, 1'b1},
    '{32'sd3,           1'b1, 1'b1},
    '{32'sd4,           1'b1, 1'b0},
    '{32'sd5,           1'b1, 1'b1},
    '{32'sd9,           1'b1, 1'b0},
    '{-32'sd1,          1'b1, 1'b0},
    '{32'sh80000000,    1'b1, 1'b0},
    '{32'sh7FFFFFFF,    1'b1, 1'b1},
    '{32'sh7FFFFFFE,    1'b1, 1'b0},
    '{32'sh55555555,    1'b1, 1'b0},
    '{32'shAAAAAAAA,    1'b1, 1'b0},
    '{32'sd25,          1'b1, 1'b0},
    '{32'sh7FFFFFFD,    1'b1, 1'b0},
    '{32'sd7,           1'b0, 1'b0},
    '{32'sd49,          1'b0, 1'b0},
    '{32'sd97,          1'b0, 1'b0},
    '{32'sd169,         1'b0, 1'b0},
    '{32'sd1021,        1'b0, 1'b0},
    '{32'sd8191,        1'b0, 1'b0},
    '{32'sd10403,       1'b0, 1'b0},
    '{32'sd65521,       1'b0, 1'b0},
    '{32'sd65537,       1'b0, 1'b0}
  };

  int idle_pct [0:3] = '{0, 46, 0, 16};

  prime_trial_division #(
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .candidate_i (candidate_i),
    .done_o      (done_o),
    .is_prime_o  (is_prime_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Primality of the candidate as the block sees it: the sign bit set means
  // negative, and odd divisors run while their square stays within the value.
  function automatic logic predict_prime(input logic [DATA_WIDTH-1:0] value);
    longint unsigned n;
    longint unsigned d;
    logic            prime;
    n = longint'(value);
    if (value[DATA_WIDTH-1] || n < 2) begin
      prime = 1'b0;
    end else if (n < 4) begin
      prime = 1'b1;
    end else if (n[0] == 1'b0) begin
      prime = 1'b0;
    end else begin
      prime = 1'b1;
      d = 3;
      while (prime && d <= n / d) begin
        if (n % d == 0) prime = 1'b0;
        d += 2;
      end
    end
    return prime;
  endfunction

  // Random candidate, mostly small so the trial loop stays short; large
  // values carry a sign bit, an even value or a factor of three.
  function automatic logic [DATA_WIDTH-1:0] random_candidate();
    logic [DATA_WIDTH-1:0] value;
    int unsigned           pick;
    int unsigned           a;
    int unsigned           b;
    pick = $urandom_range(99);
    if (pick < 45) begin
      value = $urandom_range(1023);
    end else if (pick < 55) begin
      value = $urandom_range(16383);
    end else if (pick < 67) begin
      value = {1'b1, 31'($urandom())};
    end else if (pick < 78) begin
      value = {1'b0, 30'($urandom() >> 2), 1'b0};
    end else if (pick < 89) begin
      value = 3 * $urandom_range(715827882);
    end else begin
      a = 2 * $urandom_range(63) + 3;
      b = 2 * $urandom_range(63) + 3;
      value = a * b;
    end
    return value;
  endfunction

  // Present one candidate beat and hold it until the block takes it.
  task automatic send_candidate(input logic [DATA_WIDTH-1:0] value, input logic fixed,
                                input logic fixed_prime);
    verdict_t verdict;
    start       <= 1'b1;
    candidate_i <= value;
    do @(posedge clk_i); while (busy);
    verdict.value = value;
    verdict.prime = fixed ? fixed_prime : predict_prime(value);
    pending_verdicts.push_back(verdict);
  endtask

  // Leave start low for a random number of cycles.
  task automatic idle_sender(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Hold off until every answer has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Compare each result beat with the oldest waiting answer.
  always @(posedge clk_i) begin
    verdict_t verdict;
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result beat with no candidate waiting, expected none, actual %0b",
                 $time, is_prime_o);
        fail_count++;
      end else begin
        verdict = pending_verdicts.pop_front();
        if (is_prime_o !== verdict.prime) begin
          $display("%0t: is_prime for %0d: expected %0b, actual %0b",
                   $time, $signed(verdict.value), verdict.prime, is_prime_o);
          fail_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int timeout;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    candidate_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner values, back to back.
    foreach (corner_rows[i]) begin
      send_candidate(corner_rows[i].value, corner_rows[i].fixed, corner_rows[i].prime);
    end
    drain_results();

    // Random phases; the receiver cannot stall, so only the sender idles.
    foreach (idle_pct[p]) begin
      for (int k = 0; k < PHASE_BEATS; k++) begin
        idle_sender(idle_pct[p]);
        send_candidate(random_candidate(), 1'b0, 1'b0);
      end
      drain_results();
    end

    // Let any stray beat show up before the verdict.
    timeout = 0;
    while (pending_verdicts.size() != 0 && timeout < 1000000) begin
      @(posedge clk_i);
      timeout++;
    end
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d answers never arrived, expected 0 left, actual %0d",
               $time, pending_verdicts.size(), pending_verdicts.size());
      fail_count++;
    end
    repeat (4 * TRIAL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
